// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the alu
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on clk_i, disabled in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a property on clk_i, also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/wiea_pkg.sv =====
// ----------------------------------------------------------------------------
// wiea_pkg
// shared types and constants of the wide integer alu
// ----------------------------------------------------------------------------
`default_nettype none
package wiea_pkg;
  localparam int unsigned WordBits = 64;
  localparam int unsigned OutBits = 64;
  localparam int unsigned CmdBits = 5;
  // one divider cell per quotient bit, plus an input and an output stage
  localparam int unsigned NumCells = WordBits;
  localparam int unsigned Depth = NumCells + 2;

  typedef enum logic [CmdBits-1:0] {
    CmdAdd = 5'd0, CmdSub = 5'd1, CmdMul = 5'd2, CmdDivU = 5'd3, CmdDivS = 5'd4,
    CmdModU = 5'd5, CmdModS = 5'd6, CmdNeg = 5'd7, CmdNot = 5'd8, CmdOr = 5'd9,
    CmdAnd = 5'd10, CmdXor = 5'd11, CmdXnor = 5'd12, CmdNor = 5'd13, CmdShl = 5'd14,
    CmdShr = 5'd15, CmdLor = 5'd16, CmdLand = 5'd17, CmdLnot = 5'd18, CmdLxor = 5'd19,
    CmdLxnor = 5'd20, CmdLnor = 5'd21, CmdEq = 5'd22, CmdLt = 5'd23, CmdGt = 5'd24,
    CmdLe = 5'd25, CmdGe = 5'd26, CmdNe = 5'd27, CmdSeg = 5'd28, CmdWrt = 5'd29,
    CmdSegOff = 5'd30, CmdIdent = 5'd31
  } cmd_e;

  typedef enum logic [1:0] {
    ErrNone = 2'd0, ErrMissing = 2'd1, ErrDivZero = 2'd2, ErrInvalid = 2'd3
  } err_e;

  typedef logic [WordBits-1:0] word_t;

  // sideband that travels with a request along the cell chain
  typedef struct packed {
    logic  is_div;
    logic  is_mod;
    logic  neg_q;
    logic  neg_r;
    err_e  err;
    word_t early;
  } side_t;

  typedef struct packed {
    word_t rem;
    word_t quo;
    word_t dvs;
  } div_t;
endpackage
`default_nettype wire

// ===== hw/rtl/wiea_if.sv =====
// ----------------------------------------------------------------------------
// wiea_in_if / wiea_out_if
// valid/ready channels of the alu
// ----------------------------------------------------------------------------
`default_nettype none
interface wiea_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic        has_operand;
  modport source (output valid, cmd, operand_a, operand_b, has_operand, input ready);
  modport sink (input valid, cmd, operand_a, operand_b, has_operand, output ready);
endinterface

interface wiea_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  error;
  logic        fits_short;
  modport source (output valid, value, error, fits_short, input ready);
  modport sink (input valid, value, error, fits_short, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wiea_cell.sv =====
// ----------------------------------------------------------------------------
// wiea_cell
// one restoring divide step and one stage of the request chain
// ----------------------------------------------------------------------------
`default_nettype none
module wiea_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  wiea_pkg::div_t  div_i,
  input  wiea_pkg::side_t side_i,
  output logic            valid_o,
  output wiea_pkg::div_t  div_o,
  output wiea_pkg::side_t side_o
);
  localparam int unsigned W = wiea_pkg::WordBits;
  logic [W:0]   trial;
  logic [W-1:0] rem_sh;
  wiea_pkg::div_t div_d;

  always_comb begin
    rem_sh = {div_i.rem[W-2:0], div_i.quo[W-1]};
    trial = {div_i.rem[W-1], rem_sh} - {1'b0, div_i.dvs};
    div_d.dvs = div_i.dvs;
    if (!trial[W]) begin
      div_d.rem = trial[W-1:0];
      div_d.quo = {div_i.quo[W-2:0], 1'b1};
    end else begin
      div_d.rem = rem_sh;
      div_d.quo = {div_i.quo[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o <= div_d;
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/wide_integer_expression_alu.sv =====
// ----------------------------------------------------------------------------
// wide_integer_expression_alu
// pipelined 64-bit two's complement alu with signed divide
// ----------------------------------------------------------------------------
// Takes one request per cycle while the sink is not stalling and presents the
// results in order: the input register loads at the accepting edge, then one
// divide cell per quotient bit, then the output register. Latency is set by
// the chain of divide cells; every operation travels the same chain so
// results never reorder. The whole chain advances only when the output
// register is free or being taken, so a stalled sink holds everything in
// place and nothing is lost.
`default_nettype none
`include "assert_macros.svh"
module wide_integer_expression_alu (
  input  logic clk_i,
  input  logic rst_ni,
  wiea_in_if.sink    in_i,
  wiea_out_if.source out_o
);
  localparam int unsigned W = wiea_pkg::WordBits;
  localparam int unsigned N = wiea_pkg::NumCells;
  localparam logic [63:0] ShortLim = 64'h8000_0000;

  logic en;
  logic out_valid_q;
  logic [63:0] out_value_q;
  logic [1:0]  out_err_q;
  logic        out_fit_q;

  assign en = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // ---- input stage: decode, multiply, simple ops
  wiea_pkg::word_t a, b, ma, mb, r0;
  wiea_pkg::side_t side0;
  logic [W:0] cmp;
  logic na, nb, za, zb, lt, gt;
  wiea_pkg::cmd_e cmd;

  always_comb begin
    a = in_i.operand_a[W-1:0];
    b = in_i.operand_b[W-1:0];
    cmd = wiea_pkg::cmd_e'(in_i.cmd);
    na = a[W-1];
    nb = b[W-1];
    za = (a == '0);
    zb = (b == '0);
    ma = na ? -a : a;
    mb = nb ? -b : b;
    cmp = {a[W-1], a} - {b[W-1], b};
    lt = cmp[W];
    gt = !lt && !(a == b);
    r0 = '0;
    side0.is_div = 1'b0;
    side0.is_mod = 1'b0;
    side0.neg_q = na ^ nb;
    side0.neg_r = na;
    side0.err = wiea_pkg::ErrNone;
    case (cmd)
      wiea_pkg::CmdAdd: r0 = a + b;
      wiea_pkg::CmdSub: r0 = a - b;
      wiea_pkg::CmdMul: r0 = '0;
      wiea_pkg::CmdDivU, wiea_pkg::CmdDivS: side0.is_div = 1'b1;
      wiea_pkg::CmdModU, wiea_pkg::CmdModS: side0.is_mod = 1'b1;
      wiea_pkg::CmdNeg: r0 = -a;
      wiea_pkg::CmdNot: r0 = ~a;
      wiea_pkg::CmdOr: r0 = a | b;
      wiea_pkg::CmdAnd: r0 = a & b;
      wiea_pkg::CmdXor: r0 = a ^ b;
      wiea_pkg::CmdXnor: r0 = ~(a ^ b);
      wiea_pkg::CmdNor: r0 = ~(a | b);
      wiea_pkg::CmdShl, wiea_pkg::CmdShr: begin
        if (in_i.operand_b[63] || (in_i.operand_b >= ShortLim) && nb) r0 = '0;
        else if (nb || b >= W'(ShortLim)) r0 = '0;
        else if (b >= W'(W)) r0 = (cmd == wiea_pkg::CmdShl || !na) ? '0 : '1;
        else if (cmd == wiea_pkg::CmdShl) r0 = a << b[$clog2(W)-1:0];
        else r0 = W'($signed(a) >>> b[$clog2(W)-1:0]);
      end
      wiea_pkg::CmdLor: r0 = W'(!za || !zb);
      wiea_pkg::CmdLand: r0 = W'(!za && !zb);
      wiea_pkg::CmdLnot: r0 = W'(za);
      wiea_pkg::CmdLxor: r0 = W'(za != zb);
      wiea_pkg::CmdLxnor: r0 = W'(za == zb);
      wiea_pkg::CmdLnor: r0 = W'(za && zb);
      wiea_pkg::CmdEq: r0 = W'(a == b);
      wiea_pkg::CmdLt: r0 = W'(lt);
      wiea_pkg::CmdGt: r0 = W'(gt);
      wiea_pkg::CmdLe: r0 = W'(!gt);
      wiea_pkg::CmdGe: r0 = W'(!lt);
      wiea_pkg::CmdNe: r0 = W'(a != b);
      wiea_pkg::CmdIdent: r0 = a;
      default: side0.err = wiea_pkg::ErrInvalid;
    endcase
    if ((side0.is_div || side0.is_mod) && zb) begin
      side0.err = wiea_pkg::ErrDivZero;
    end
    if (!in_i.has_operand && !(cmd == wiea_pkg::CmdNeg || cmd == wiea_pkg::CmdNot ||
        cmd == wiea_pkg::CmdLnot)) begin
      side0.err = wiea_pkg::ErrMissing;
    end
    side0.early = r0;
  end

  // multiply split into three 32x32 partial products over two registered stages
  localparam int unsigned H = 32;
  logic [H-1:0] al, ah, bl, bh;
  logic [2*H-1:0] p_ll_q, p_lh_q, p_hl_q;
  logic is_mul_q;
  logic [W-1:0] mul_res_q;
  logic is_mul2_q;

  always_comb begin
    al = a[H-1:0];
    ah = H'({{(2*H-W){1'b0}}, a} >> H);
    bl = b[H-1:0];
    bh = H'({{(2*H-W){1'b0}}, b} >> H);
  end

  // ---- cell chain
  logic           vld [N+1];
  wiea_pkg::div_t dv  [N+1];
  wiea_pkg::side_t sd [N+1];
  logic v0_q;
  wiea_pkg::div_t d0_q;
  wiea_pkg::side_t s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q.rem <= '0;
      d0_q.quo <= ma;
      d0_q.dvs <= mb;
      s0_q <= side0;
      p_ll_q <= al * bl;
      p_lh_q <= al * bh;
      p_hl_q <= ah * bl;
      is_mul_q <= (cmd == wiea_pkg::CmdMul);
      mul_res_q <= W'({{(2*H-W){1'b0}}, p_ll_q} + ({{(2*H-W){1'b0}}, p_lh_q + p_hl_q} << H));
      is_mul2_q <= is_mul_q;
    end
  end

  // the product joins the request one stage down the chain
  always_comb begin
    vld[0] = v0_q;
    dv[0] = d0_q;
    sd[0] = s0_q;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    wiea_pkg::side_t s_in;
    always_comb begin
      s_in = sd[i];
      if (i == 1 && is_mul2_q) s_in.early = mul_res_q;
    end
    wiea_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(vld[i]), .div_i(dv[i]), .side_i(s_in),
      .valid_o(vld[i+1]), .div_o(dv[i+1]), .side_o(sd[i+1])
    );
  end

  // ---- output stage
  wiea_pkg::side_t sl;
  wiea_pkg::word_t res;
  logic [63:0] res64, mag;

  always_comb begin
    sl = sd[N];
    if (sl.is_div) res = sl.neg_q ? -dv[N].quo : dv[N].quo;
    else if (sl.is_mod) res = sl.neg_r ? -dv[N].rem : dv[N].rem;
    else res = sl.early;
    res64 = {{(64-W){res[W-1]}}, res};
    mag = res64[63] ? -res64 : res64;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sl.err != wiea_pkg::ErrNone) begin
        out_value_q <= '0;
        out_fit_q <= 1'b0;
      end else begin
        out_value_q <= res64;
        out_fit_q <= (mag < ShortLim);
      end
      out_err_q <= sl.err;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_value_q;
  assign out_o.error = out_err_q;
  assign out_o.fits_short = out_fit_q;

  `ASSERT_CLK(a_stall_hold, out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_value_q), "result changed while stalled")
  `ASSERT_CLK(a_err_zero, out_valid_q && out_err_q != wiea_pkg::ErrNone |-> out_value_q == '0 && !out_fit_q, "error result not cleared")
  `ASSERT_CLK(a_ready_free, !out_valid_q |-> in_i.ready, "not ready with free output")
endmodule
`default_nettype wire
